### rtl/sdc_pkg.sv
`timescale 1ns / 1ps

package sdc_pkg;

  // frame limits and field widths
  localparam int MAX_FRAME_RAW = 512;
  localparam int CNT_W         = 10;
  localparam int SUM_W         = 17;

  // queue between classifier and frame engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // framing codes
  localparam logic [7:0] END_CODE  = 8'hC0;
  localparam logic [7:0] ESC_CODE  = 8'hDB;
  localparam logic [7:0] END_SUBST = 8'hDC;
  localparam logic [7:0] ESC_SUBST = 8'hDD;

  // frame status codes
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_BAD_SUM  = 2'd2;
  localparam logic [1:0] ST_OVERSIZE = 2'd3;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_ESC,
    KIND_END
  } kind_t;

  // one classified raw byte
  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
    logic [7:0] unesc;
  } item_t;

endpackage

### rtl/slip_deframer_checksum_check.sv
`timescale 1ns / 1ps

// SLIP deframer with checksum check. Takes one raw byte per beat on s_*;
// 0xC0 ends a frame and 0xDB escapes the next byte. Decoded bytes come out
// on m_* one byte late, so the last byte of a frame is kept back as the
// checksum (inverted, once-folded sum of the earlier bytes). At each frame end
// one beat with tlast high carries status (good, too short, bad checksum) and
// the decoded length; empty frames give no beat. The first raw byte beyond
// max_raw_bytes (cfg_data, capped at 512, reset 512) is dropped with an
// oversize beat and clears the frame state. The block takes one byte every
// cycle while m_tready is high; a byte classified on entry sits in a
// two-entry queue, and its result passes through the frame engine into an
// output register before it is presented on m_*. The frame engine sets the
// rate; m_tready low stalls it and then fills the queue.
module slip_deframer_checksum_check import sdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,    // max_raw_bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,     // out_byte[7:0], frame_status[9:8],
                                   // decoded_length[19:10], zero[23:20]
  output logic        m_tlast      // is_end
);

  item_t            front_item;
  item_t            head_item;
  logic             q_full;
  logic             head_valid;
  logic             pop;
  logic [7:0]       out_byte;
  logic [1:0]       out_status;
  logic [CNT_W-1:0] out_length;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;

  sdc_front u_front (
    .rx_byte (s_tdata),
    .item    (front_item)
  );

  sdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  sdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (out_byte),
    .out_last   (m_tlast),
    .out_status (out_status),
    .out_length (out_length)
  );

  // pack result fields, highest first
  assign m_tdata = {4'b0000, out_length, out_status, out_byte};

endmodule

### rtl/sdc_front.sv
`timescale 1ns / 1ps

module sdc_front import sdc_pkg::*; (
  input  logic [7:0] rx_byte,
  output item_t      item
);

  // classify the raw byte and precompute its unescaped value
  always_comb begin
    item.raw = rx_byte;
    if (rx_byte == END_CODE) begin
      item.kind = KIND_END;
    end else if (rx_byte == ESC_CODE) begin
      item.kind = KIND_ESC;
    end else begin
      item.kind = KIND_DATA;
    end
    if (rx_byte == END_SUBST) begin
      item.unesc = END_CODE;
    end else if (rx_byte == ESC_SUBST) begin
      item.unesc = ESC_CODE;
    end else begin
      item.unesc = rx_byte;
    end
  end

endmodule

### rtl/sdc_queue.sv
`timescale 1ns / 1ps

module sdc_queue import sdc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && head_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/sdc_back.sv
`timescale 1ns / 1ps

module sdc_back import sdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             head_valid,
  input  item_t            head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] out_length
);

  logic [CNT_W-1:0] max_raw_bytes;
  logic [CNT_W-1:0] raw_count, raw_count_next;
  logic             escape_pending, escape_pending_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic [CNT_W-1:0] decoded_count, decoded_count_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;

  logic             adv;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic [1:0]       emit_status;
  logic [CNT_W-1:0] emit_length;

  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] end_count;
  logic [7:0]       end_held;
  logic [9:0]       folded;
  logic [7:0]       chk;

  // output register frees up when empty or being taken
  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  assign limit = (max_raw_bytes < CNT_W'(MAX_FRAME_RAW)) ? max_raw_bytes
                                                         : CNT_W'(MAX_FRAME_RAW);

  // a pending escape at frame end becomes the final literal byte
  assign end_count = decoded_count + CNT_W'(escape_pending);
  assign end_held  = escape_pending ? ESC_CODE : held_byte;
  assign folded    = {2'b00, running_sum[7:0]} + {1'b0, running_sum[SUM_W-1:8]};
  assign chk       = folded[7:0] ^ 8'hFF;

  // frame engine next state and result
  always_comb begin
    raw_count_next      = raw_count;
    escape_pending_next = escape_pending;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    decoded_count_next  = decoded_count;
    running_sum_next    = running_sum;
    emit                = 1'b0;
    emit_byte           = '0;
    emit_last           = 1'b0;
    emit_status         = ST_GOOD;
    emit_length         = '0;
    if (pop) begin
      if (head_item.kind == KIND_END) begin
        if (end_count != '0) begin
          emit        = 1'b1;
          emit_last   = 1'b1;
          emit_length = end_count;
          if (end_count < CNT_W'(3)) begin
            emit_status = ST_SHORT;
          end else begin
            emit_status = (chk == end_held) ? ST_GOOD : ST_BAD_SUM;
          end
        end
        raw_count_next      = '0;
        escape_pending_next = 1'b0;
        held_byte_next      = '0;
        held_valid_next     = 1'b0;
        decoded_count_next  = '0;
        running_sum_next    = '0;
      end else if (raw_count >= limit) begin
        // oversize abort, byte dropped
        emit                = 1'b1;
        emit_last           = 1'b1;
        emit_status         = ST_OVERSIZE;
        emit_length         = decoded_count;
        raw_count_next      = '0;
        escape_pending_next = 1'b0;
        held_byte_next      = '0;
        held_valid_next     = 1'b0;
        decoded_count_next  = '0;
        running_sum_next    = '0;
      end else begin
        raw_count_next = raw_count + 1'b1;
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          held_byte_next      = head_item.unesc;
          held_valid_next     = 1'b1;
          decoded_count_next  = decoded_count + 1'b1;
        end else begin
          // release the held byte ahead of the new one
          if (held_valid) begin
            emit             = 1'b1;
            emit_byte        = held_byte;
            running_sum_next = running_sum + {{(SUM_W-8){1'b0}}, held_byte};
          end
          if (head_item.kind == KIND_ESC) begin
            escape_pending_next = 1'b1;
            held_valid_next     = 1'b0;
          end else begin
            held_byte_next     = head_item.raw;
            held_valid_next    = 1'b1;
            decoded_count_next = decoded_count + 1'b1;
          end
        end
      end
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_raw_bytes <= CNT_W'(MAX_FRAME_RAW);
    end else if (cfg_valid) begin
      max_raw_bytes <= cfg_data;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count      <= '0;
      escape_pending <= 1'b0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      decoded_count  <= '0;
      running_sum    <= '0;
    end else begin
      raw_count      <= raw_count_next;
      escape_pending <= escape_pending_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      decoded_count  <= decoded_count_next;
      running_sum    <= running_sum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_byte   <= emit_byte;
      out_last   <= emit_last;
      out_status <= emit_status;
      out_length <= emit_length;
    end
  end

`ifndef ASSERT_OFF
  a_hold_empty_on_escape: assert property (@(posedge clk) disable iff (rst)
    !(escape_pending && held_valid))
    else $error("held byte present while escape pending");

  a_raw_in_range: assert property (@(posedge clk) disable iff (rst)
    raw_count <= CNT_W'(MAX_FRAME_RAW))
    else $error("raw count beyond frame limit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.kind == KIND_END |=> decoded_count == '0 && !escape_pending)
    else $error("frame state not cleared after end byte");

  a_end_beat_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_byte == '0)
    else $error("end beat carries a data byte");

  a_data_beat_no_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_status == ST_GOOD && out_length == '0)
    else $error("data beat carries status");
`endif

endmodule
